// ----- hdl/hexd_pkg.sv -----
// Shared types, constants and hex helpers for the inline hex escape decoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package hexd_pkg;

  localparam logic [7:0] BSLASH   = 8'h5C;
  localparam logic [7:0] LETTER_X = 8'h78;

  // Most result bytes one input byte can release.
  localparam int GRP_SLOTS = 4;
  localparam int GRP_CNT_W = $clog2(GRP_SLOTS + 1);
  localparam int GRP_IDX_W = $clog2(GRP_SLOTS);

  // Result group produced by one input byte. Only slot 0 can be flagged.
  typedef struct packed {
    logic [GRP_CNT_W-1:0]           n;
    logic [GRP_SLOTS-1:0][7:0]      bytes;
    logic                           mal;
    logic                           last;
  } hexd_grp_t;

  function automatic logic hex_ok(input logic [7:0] b);
    logic dig, lc, uc;
    dig = (b >= 8'h30) && (b <= 8'h39);
    lc  = (b >= 8'h61) && (b <= 8'h66);
    uc  = (b >= 8'h41) && (b <= 8'h46);
    return dig || lc || uc;
  endfunction

  // Valid only where hex_ok holds; letters map via low nibble + 9.
  function automatic logic [3:0] hex_nib(input logic [7:0] b);
    logic [3:0] v;
    if (b[6]) begin
      v = b[3:0] + 4'd9;
    end else begin
      v = b[3:0];
    end
    return v;
  endfunction

endpackage

// ----- hdl/hexd_scan.sv -----
// Input register and escape scanner: holds the pending escape state and
// turns one input byte into a group of up to four result bytes. Uses hexd_pkg.
`timescale 1ns / 1ps

module hexd_scan (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [7:0]         in_byte,
  input  logic               in_last,
  output logic               in_stall,
  input  logic               can_load,
  output logic               load,
  output hexd_pkg::hexd_grp_t grp
);
  import hexd_pkg::*;

  logic       in_full;
  logic [7:0] cur_byte;
  logic       cur_last;
  logic [1:0] cnt;
  logic [7:0] held2;
  logic [1:0] cnt_next;
  logic [7:0] held2_next;
  logic       take;
  logic       is_bs;
  logic       is_hex;

  assign is_bs  = (cur_byte == BSLASH);
  assign is_hex = hex_ok(cur_byte);

  always_comb begin
    grp        = '0;
    cnt_next   = cnt;
    held2_next = held2;
    grp.last   = cur_last;
    if (cur_last && (cnt != 2'd3)) begin
      // string ends before an escape can complete: pass everything through
      cnt_next = 2'd0;
      unique case (cnt)
        2'd0: begin
          grp.bytes[0] = cur_byte;
          grp.n        = GRP_CNT_W'(1);
        end
        2'd1: begin
          grp.bytes[0] = BSLASH;
          grp.bytes[1] = cur_byte;
          grp.n        = GRP_CNT_W'(2);
        end
        default: begin
          grp.bytes[0] = BSLASH;
          grp.bytes[1] = LETTER_X;
          grp.bytes[2] = cur_byte;
          grp.n        = GRP_CNT_W'(3);
        end
      endcase
    end else begin
      unique case (cnt)
        2'd0: begin
          if (is_bs) begin
            cnt_next = 2'd1;
          end else begin
            grp.bytes[0] = cur_byte;
            grp.n        = GRP_CNT_W'(1);
          end
        end
        2'd1: begin
          if (cur_byte == LETTER_X) begin
            cnt_next = 2'd2;
          end else begin
            grp.bytes[0] = BSLASH;
            if (is_bs) begin
              grp.n    = GRP_CNT_W'(1);
              cnt_next = 2'd1;
            end else begin
              grp.bytes[1] = cur_byte;
              grp.n        = GRP_CNT_W'(2);
              cnt_next     = 2'd0;
            end
          end
        end
        2'd2: begin
          if (is_hex) begin
            cnt_next   = 2'd3;
            held2_next = cur_byte;
          end else begin
            grp.bytes[0] = BSLASH;
            grp.mal      = 1'b1;
            grp.bytes[1] = LETTER_X;
            if (is_bs) begin
              grp.n    = GRP_CNT_W'(2);
              cnt_next = 2'd1;
            end else begin
              grp.bytes[2] = cur_byte;
              grp.n        = GRP_CNT_W'(3);
              cnt_next     = 2'd0;
            end
          end
        end
        default: begin
          cnt_next = 2'd0;
          if (is_hex) begin
            grp.bytes[0] = {hex_nib(held2), hex_nib(cur_byte)};
            grp.n        = GRP_CNT_W'(1);
          end else begin
            grp.bytes[0] = BSLASH;
            grp.mal      = 1'b1;
            grp.bytes[1] = LETTER_X;
            grp.bytes[2] = held2;
            if (is_bs && !cur_last) begin
              grp.n    = GRP_CNT_W'(3);
              cnt_next = 2'd1;
            end else begin
              // a trailing backslash at end of string is flushed here too
              grp.bytes[3] = cur_byte;
              grp.n        = GRP_CNT_W'(4);
            end
          end
        end
      endcase
    end
  end

  // Groups with no bytes retire without touching the output side.
  assign take     = in_full && ((grp.n == '0) || can_load);
  assign load     = in_full && (grp.n != '0) && can_load;
  assign in_stall = in_full && !take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
      cnt     <= 2'd0;
    end else begin
      if (!in_stall) begin
        in_full <= in_valid;
      end
      if (take) begin
        cnt <= cnt_next;
      end
    end
    if (in_valid && !in_stall) begin
      cur_byte <= in_byte;
      cur_last <= in_last;
    end
    if (take) begin
      held2 <= held2_next;
    end
  end

endmodule

// ----- hdl/hexd_emit.sv -----
// Result register bank: holds one group of result bytes and hands them out
// one byte per cycle while out_stall is low. Uses hexd_pkg.
`timescale 1ns / 1ps

module hexd_emit (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  hexd_pkg::hexd_grp_t grp_in,
  output logic                can_load,
  output logic                out_valid,
  output logic [7:0]          out_byte,
  output logic                malformed,
  output logic                out_last,
  input  logic                out_stall
);
  import hexd_pkg::*;

  hexd_grp_t            grp;
  logic [GRP_CNT_W-1:0] rem;
  logic [GRP_IDX_W-1:0] idx;
  logic                 pop;

  assign out_valid = (rem != '0);
  assign pop       = out_valid && !out_stall;
  // room for a new group when empty or once the last pending byte leaves this cycle
  assign can_load  = (rem == '0) || ((rem == GRP_CNT_W'(1)) && !out_stall);

  assign out_byte  = grp.bytes[idx];
  assign malformed = grp.mal && (idx == '0);
  assign out_last  = grp.last && (rem == GRP_CNT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= '0;
      idx <= '0;
    end else if (load) begin
      rem <= grp_in.n;
      idx <= '0;
    end else if (pop) begin
      rem <= rem - GRP_CNT_W'(1);
      idx <= idx + GRP_IDX_W'(1);
    end
    if (load) begin
      grp <= grp_in;
    end
  end

endmodule

// ----- hdl/inline_hex_escape_decoder.sv -----
// Top level of the inline hex escape decoder: scanner feeding the result bank.
// Depends on hexd_pkg, hexd_scan and hexd_emit.
`timescale 1ns / 1ps

//  channel  signals                                   handshake
//  input    in_byte, in_last                          in_valid / in_stall
//  output   out_byte, malformed, out_last             out_valid / out_stall
//
// Plain bytes pass the input register, then the result bank, one per cycle
// while out_stall is low. A failed or cut-off escape yields up to four bytes,
// sent from the bank one per cycle unless stalled; the input register stalls
// until the bank drains. Bytes held inside an escape produce nothing until
// the escape resolves. rst is synchronous, active high; it drops any pending
// escape and results. out_stall reaches in_stall through the bank's load check.
module inline_hex_escape_decoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       in_stall,
  output logic       out_valid,
  output logic [7:0] out_byte,
  output logic       malformed,
  output logic       out_last,
  input  logic       out_stall
);
  import hexd_pkg::*;

  hexd_grp_t grp;
  logic      load;
  logic      can_load;

  hexd_scan u_scan (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .in_stall (in_stall),
    .can_load (can_load),
    .load     (load),
    .grp      (grp)
  );

  hexd_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .grp_in    (grp),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_byte  (out_byte),
    .malformed (malformed),
    .out_last  (out_last),
    .out_stall (out_stall)
  );

endmodule

// ----- hdl/hexd_checker.sv -----
// Port-level checks for the inline hex escape decoder, bound to the top level.
// Depends on hexd_pkg for the character codes.
`timescale 1ns / 1ps

module hexd_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic [7:0] out_byte,
  input logic       malformed,
  input logic       out_last,
  input logic       out_stall
);
  import hexd_pkg::*;

  // A flagged result is always the backslash of the bad escape.
  a_mal_is_bslash: assert property (@(posedge clk) disable iff (rst)
    (out_valid && malformed) |-> (out_byte == BSLASH))
    else $error("malformed flag on a byte other than backslash");

  // More bytes of the failed escape always follow, so it never ends a string.
  a_mal_not_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && malformed) |-> !out_last)
    else $error("malformed result marked as end of string");

  // The 'x' follows the flagged backslash in the very next cycle.
  a_mal_then_x: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && malformed) |=> (out_valid && out_byte == LETTER_X))
    else $error("flagged backslash not followed by x");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_byte) && $stable(malformed) && $stable(out_last)))
    else $error("stalled result changed");

endmodule

bind inline_hex_escape_decoder hexd_checker u_hexd_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_byte  (out_byte),
  .malformed (malformed),
  .out_last  (out_last),
  .out_stall (out_stall)
);
